>>> hdl/md5_pkg.sv
// md5 constants, round tables and controller types
package md5_pkg;

	// initial chaining words a b c d
	localparam logic [31:0] MD5_IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	// padding marker byte
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// additive round constants
	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, indexed by {quarter, round mod 4}
	localparam logic [4:0] MD5_ROT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	// controller states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} md5_state_t;

	// padding phases
	typedef enum logic [3:0] {
		PH_PAD80  = 4'b0001,
		PH_ZERO   = 4'b0010,
		PH_LEN_HI = 4'b0100,
		PH_DONE   = 4'b1000
	} md5_phase_t;

	// message word index used by a round
	function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
		logic [3:0] r4;
		logic [3:0] g;
		r4 = rnd[3:0];
		case (rnd[5:4])
			2'd0:    g = r4;
			2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
			2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
			default: g = 4'(r4 * 4'd7);
		endcase
		return g;
	endfunction

	// round mixing function
	function automatic logic [31:0] md5_mix(input logic [1:0] quarter,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (quarter)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (b & d) | (c & ~d);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	// left rotate by a nonzero amount
	function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] wide;
		wide = {x, x} << s;
		return wide[63:32];
	endfunction

endpackage

>>> hdl/md5_message_digest.sv
// md5 digest engine: block store memory, padding sequencer and round datapath
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tdata: message_word, byte_count; tlast: final_item
//  m_*     | out | m_tvalid/m_tready  | tdata: digest_word; tuser: word_index; tlast: last_result
//
// a non-final word is written into the block store as it is accepted; the word that completes
// a 16-word block adds a compression (load, 64 rounds at one per cycle, fold), so a long
// message is paced by the single round unit and the one read port of the block store. the
// final word adds the padding words and one or two compressions, then four result transfers.
// the input stalls during all of it.
// reset loads the initial chaining words and empties the block; the store needs no clearing.
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] byte_count, [39:35] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_index
	output logic        m_tlast
);
	import md5_pkg::*;

	md5_state_t  state_q;
	md5_phase_t  phase_q;
	logic [31:0] chain_q [4];
	logic [31:0] round_q [4];
	logic [3:0]  fill_q;
	logic [63:0] bit_len_q;
	logic [5:0]  rnd_q;
	logic        final_q;
	logic [31:0] pad_q;
	logic [31:0] pre_q;
	logic [1:0]  out_idx_q;

	logic [31:0] block_mem [16];
	logic [31:0] rdata_q;

	logic        in_xfer;
	logic        out_xfer;
	logic [31:0] in_word;
	logic [2:0]  eff_count;
	logic        in_full;
	logic [31:0] in_pad;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [31:0] pad_data;
	logic [3:0]  raddr;
	logic [31:0] mix;
	logic [31:0] sum;
	logic [31:0] new_b;

	// handshake and output view
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign out_xfer = m_tvalid && m_tready;
	assign m_tdata  = chain_q[out_idx_q];
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == 2'd3);

	// input word decode: count saturates, non-final words are always full
	assign in_word = s_tdata[31:0];
	always_comb begin
		if (!s_tlast || s_tdata[34:32] > 3'd4) begin
			eff_count = 3'd4;
		end else begin
			eff_count = s_tdata[34:32];
		end
		in_full = (eff_count == 3'd4);
		case (eff_count)
			3'd1:    in_pad = {16'h0, PAD_BYTE, in_word[7:0]};
			3'd2:    in_pad = {8'h0, PAD_BYTE, in_word[15:0]};
			3'd3:    in_pad = {PAD_BYTE, in_word[23:0]};
			default: in_pad = {24'h0, PAD_BYTE};
		endcase
	end

	// padding word for the current phase
	always_comb begin
		case (phase_q)
			PH_PAD80:  pad_data = pad_q;
			PH_ZERO:   pad_data = (fill_q == 4'd14) ? bit_len_q[31:0] : 32'h0;
			PH_LEN_HI: pad_data = bit_len_q[63:32];
			default:   pad_data = 32'h0;
		endcase
	end

	// block store write port
	assign wr_en   = (in_xfer && in_full) || (state_q == ST_PAD);
	assign wr_data = (state_q == ST_PAD) ? pad_data : in_word;

	// read address runs one round ahead of the datapath
	assign raddr = (state_q == ST_LOAD) ? md5_msg_index(6'd0)
	                                    : md5_msg_index(6'(rnd_q + 6'd1));

	// block store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			block_mem[fill_q] <= wr_data;
		end
		rdata_q <= block_mem[raddr];
	end

	// one md5 round; pre_q already holds a + round constant
	always_comb begin
		mix   = md5_mix(rnd_q[5:4], round_q[1], round_q[2], round_q[3]);
		sum   = mix + pre_q + rdata_q;
		new_b = round_q[1] + md5_rotl(sum, MD5_ROT[{rnd_q[5:4], rnd_q[1:0]}]);
	end

	// working words and pre-added constant
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				for (int k = 0; k < 4; k++) begin
					round_q[k] <= chain_q[k];
				end
				pre_q <= chain_q[0] + MD5_K[0];
			end
			ST_ROUND: begin
				round_q[0] <= round_q[3];
				round_q[1] <= new_b;
				round_q[2] <= round_q[1];
				round_q[3] <= round_q[2];
				pre_q      <= round_q[3] + MD5_K[6'(rnd_q + 6'd1)];
			end
			default: begin
			end
		endcase
		if (in_xfer && s_tlast) begin
			pad_q <= in_pad;
		end
	end

	// controller, chaining words and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_PAD80;
			fill_q    <= '0;
			bit_len_q <= '0;
			rnd_q     <= '0;
			final_q   <= 1'b0;
			out_idx_q <= '0;
			for (int k = 0; k < 4; k++) begin
				chain_q[k] <= MD5_IV[k];
			end
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 4'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						bit_len_q <= bit_len_q + 64'({eff_count, 3'b000});
						final_q   <= s_tlast;
						phase_q   <= PH_PAD80;
						if (in_full && fill_q == 4'd15) begin
							state_q <= ST_LOAD;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					case (phase_q)
						PH_PAD80:  phase_q <= PH_ZERO;
						PH_ZERO: begin
							if (fill_q == 4'd14) begin
								phase_q <= PH_LEN_HI;
							end
						end
						PH_LEN_HI: phase_q <= PH_DONE;
						default:   phase_q <= PH_DONE;
					endcase
					if (fill_q == 4'd15) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int k = 0; k < 4; k++) begin
						chain_q[k] <= chain_q[k] + round_q[k];
					end
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (phase_q == PH_DONE) begin
						state_q   <= ST_OUT;
						out_idx_q <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (out_idx_q == 2'd3) begin
							// back to the empty-message state
							state_q   <= ST_IDLE;
							final_q   <= 1'b0;
							bit_len_q <= '0;
							for (int k = 0; k < 4; k++) begin
								chain_q[k] <= MD5_IV[k];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a finished final compression always leads to the digest
	a_fold_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD && final_q && phase_q == PH_DONE) |=> m_tvalid)
		else $error("digest not presented after last compression");

	// the digest is only shown with an empty block store
	a_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (fill_q == 4'd0 && final_q))
		else $error("digest shown with block words pending");

	// the last transfer clears the length for the next message
	a_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast) |=> (bit_len_q == 64'd0 && s_tready))
		else $error("message state not cleared after digest");

	// rounds start at zero after every load
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> (state_q == ST_ROUND && rnd_q == 6'd0))
		else $error("round counter not restarted");
`endif

endmodule

>>> tb/sv/tb_md5_message_digest.sv
// self-checking testbench for the md5 digest engine: stream driver, monitor and digest predictor
module tb_md5_message_digest;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 150;

	// rotate amounts per quarter and round position
	localparam int ROT_AMT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest;
		logic [1:0]  index;
		logic        last;
	} digest_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [31:0] message_word, [34:32] byte_count, [39:35] zero
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] digest_word
	logic [1:0]  m_tuser;        // [1:0] word_index
	logic        m_tlast;

	md5_message_digest dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// stimulus and expectation stores
	msg_item_t   word_queue [$];
	digest_out_t pending_digests [$];
	int          queued_items = 0;
	int          accepted_items = 0;
	int          fail_count = 0;
	logic        s_fire = 1'b0;
	bit          calm = 1'b0;
	int          hold_req = 0;

	// predictor state
	logic [31:0] round_k [64];
	logic [31:0] digest_chain [4];
	logic [31:0] msg_block [16];
	int          block_words;
	logic [63:0] msg_bits;

	initial begin
		forever #5 clk = ~clk;
	end

	// back to the initial chaining words, empty block
	function automatic void restart_digest();
		digest_chain[0] = 32'h67452301;
		digest_chain[1] = 32'hefcdab89;
		digest_chain[2] = 32'h98badcfe;
		digest_chain[3] = 32'h10325476;
		block_words = 0;
		msg_bits = '0;
	endfunction

	// 64 rounds over the held block, folded into the chain
	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, sum;
		int g, s;
		a = digest_chain[0];
		b = digest_chain[1];
		c = digest_chain[2];
		d = digest_chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			s = ROT_AMT[(r / 16) * 4 + r % 4];
			sum = f + a + round_k[r] + msg_block[g];
			a = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
		end
		digest_chain[0] += a;
		digest_chain[1] += b;
		digest_chain[2] += c;
		digest_chain[3] += d;
	endfunction

	function automatic void absorb_word(logic [31:0] w);
		msg_block[block_words] = w;
		block_words = (block_words + 1) % 16;
		if (block_words == 0)
			compress_block();
	endfunction

	// one accepted word; the final one pads, appends the length and yields the digest
	function automatic void hash_word(logic [31:0] w, logic [2:0] count, logic last);
		int n;
		logic [31:0] pad;
		if (!last) begin
			msg_bits += 64'd32;
			absorb_word(w);
		end else begin
			n = (count > 3'd4) ? 4 : int'(count);
			msg_bits += 64'(8 * n);
			if (n == 4) begin
				absorb_word(w);
				pad = 32'h80;
			end else if (n == 0) begin
				pad = 32'h80;
			end else begin
				pad = (w & ((32'h1 << (8 * n)) - 32'h1)) | (32'h80 << (8 * n));
			end
			absorb_word(pad);
			// no room for the length: finish this block first
			if (block_words > 14)
				while (block_words != 0)
					absorb_word('0);
			while (block_words < 14)
				absorb_word('0);
			absorb_word(msg_bits[31:0]);
			absorb_word(msg_bits[63:32]);
			for (int k = 0; k < 4; k++)
				pending_digests.push_back('{digest_chain[k], 2'(k), k == 3});
			restart_digest();
		end
	endfunction

	function automatic int pick_gap_rate();
		case ($urandom_range(2))
			0:       return 0;
			1:       return 10;
			default: return 35;
		endcase
	endfunction

	// sender: holds each word until its transfer, random gaps between words
	int tx_gap = 0;
	int tx_gap_rate = 10;
	always @(negedge clk) begin : drive_words
		msg_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(99) < tx_gap_rate) begin
				tx_gap <= $urandom_range(12);
				s_tvalid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				nxt = word_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, nxt.count, nxt.word};
				s_tlast <= nxt.last;
				if ($urandom_range(47) == 0)
					tx_gap_rate <= pick_gap_rate();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, and a long hold-off on request
	int rx_stall = 0;
	int rx_hold_seen = 0;
	int rx_gap_rate = 10;
	always @(negedge clk) begin
		if (rx_hold_seen != hold_req) begin
			rx_hold_seen <= hold_req;
			rx_stall <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(99) < rx_gap_rate) begin
			rx_stall <= $urandom_range(12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		if ($urandom_range(63) == 0)
			rx_gap_rate <= pick_gap_rate();
	end

	// monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin : monitor
		digest_out_t got, want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				hash_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
				accepted_items++;
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser, m_tlast};
				if (pending_digests.size() == 0) begin
					$display("%0t unexpected digest: expected none, got %h idx %0d last %0b",
						$time, got.digest, got.index, got.last);
					fail_count++;
				end else begin
					want = pending_digests.pop_front();
					if (got != want) begin
						$display("%0t mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
							$time, want.digest, want.index, want.last,
							got.digest, got.index, got.last);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog: too long without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic queue_word(logic [31:0] w, logic [2:0] count, logic last);
		word_queue.push_back('{w, count, last});
		queued_items++;
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly full non-final words, some with a stray byte count; random tail count
	task automatic queue_random_message();
		int len;
		int cnt;
		len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(20);
		for (int i = 0; i < len; i++)
			queue_word(random_word(),
				($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
		cnt = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(4);
		queue_word(random_word(), 3'(cnt), 1'b1);
	endtask

	// sender waits until every digest is out
	task automatic wait_drained();
		while (accepted_items != queued_items || pending_digests.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		real x;
		integer hi, lo;
		// round constants from the sine table
		for (int i = 0; i < 64; i++) begin
			x = $sin(i + 1.0);
			if (x < 0.0)
				x = -x;
			x = x * 4294967296.0;
			hi = $rtoi(x / 65536.0);
			lo = $rtoi(x - $itor(hi) * 65536.0);
			round_k[i] = {hi[15:0], lo[15:0]};
		end
		restart_digest();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty message
		queue_word(32'h0, 3'd0, 1'b1);
		// partial final words, unused bytes must be masked
		queue_word(32'hffffffff, 3'd1, 1'b1);
		queue_word(32'hffffffff, 3'd2, 1'b1);
		queue_word(32'hffffffff, 3'd3, 1'b1);
		// byte counts above four saturate
		queue_word(32'hffffffff, 3'd5, 1'b1);
		queue_word(32'hffffffff, 3'd6, 1'b1);
		queue_word(32'hffffffff, 3'd7, 1'b1);
		// non-final words ignore their byte count
		queue_word(32'h00000000, 3'd0, 1'b0);
		queue_word(32'hffffffff, 3'd7, 1'b0);
		queue_word(32'ha5a5a5a5, 3'd4, 1'b0);
		queue_word(32'hffffffff, 3'd4, 1'b1);
		// length no longer fits: one extra block
		for (int i = 0; i < 13; i++)
			queue_word($urandom, 3'd4, 1'b0);
		queue_word(32'h0, 3'd4, 1'b1);
		wait_drained();

		// random messages with the receiver held off at the start
		hold_req++;
		while (queued_items < 200)
			queue_random_message();
		wait_drained();

		hold_req++;
		while (queued_items < 410)
			queue_random_message();
		wait_drained();

		// closing stretch at full rate on both sides
		calm = 1'b1;
		while (queued_items < 470)
			queue_random_message();

		while (accepted_items != queued_items)
			@(posedge clk);
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
